### rtl/core/bat_pkg.sv
// Shared types, constants and helpers for the buddy allocator tree.
// No dependencies; imported by every module under rtl/core.
package bat_pkg;

    localparam int LEVELS    = 8;
    localparam int NODE_CNT  = (1 << LEVELS) - 1;
    localparam int POS_W     = LEVELS - 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int IDX_W     = LEVELS;
    localparam int MAX_SHIFT = 16;
    localparam int SHIFT_W   = 5;
    localparam int DATA_W    = 24;
    localparam int BYTE_W    = MAX_SHIFT + LEVELS - 1;
    localparam int STAT_W    = 3;

    typedef logic [1:0] t_node;

    localparam t_node N_FREE  = 2'd0;
    localparam t_node N_SPLIT = 2'd1;
    localparam t_node N_USED  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FREED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd2;
    localparam logic [STAT_W-1:0] ST_TOOBIG  = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_node            wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] offset;
    } t_result;

    // Heap index of the node at position pos on level lvl.
    function automatic logic [IDX_W-1:0] node_idx(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
        logic [IDX_W-1:0] base;
        base = (IDX_W'(1) << lvl) - IDX_W'(1);
        return base + IDX_W'(pos);
    endfunction

endpackage

### rtl/core/bat_node_ram.sv
// Node state memory: one write and one registered read per cycle.
// Depends on bat_pkg. Per-entry valid bits make unwritten nodes read as free.
module bat_node_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bat_pkg::t_ram_req i_req,
    output bat_pkg::t_node    o_rdata
);
    import bat_pkg::*;

    t_node                mem [NODE_CNT];
    logic  [NODE_CNT-1:0] r_valid;
    t_node                r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_valid[i_req.raddr] ? mem[i_req.raddr] : N_FREE;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bat_engine.sv
// Request sequencer: tree search, split marking, walk down and buddy merge.
// Depends on bat_pkg and drives bat_node_ram through a t_ram_req struct.
module bat_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic                          i_action,
    input  logic [bat_pkg::DATA_W-1:0]    i_size,
    input  logic [bat_pkg::DATA_W-1:0]    i_offset,
    input  logic [bat_pkg::SHIFT_W-1:0]   i_shift,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output bat_pkg::t_result              o_res,
    output bat_pkg::t_ram_req             o_ram,
    input  bat_pkg::t_node                i_rdata
);
    import bat_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_UP    = 3'd4;
    localparam logic [2:0] S_FWALK = 3'd5;
    localparam logic [2:0] S_FSIB  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic               r_act;
    logic [DATA_W-1:0]  r_d;
    logic               r_zero;
    logic               r_aligned;
    logic [SHIFT_W-1:0] r_shift;
    logic [LVL_W-1:0]   r_goal, n_goal;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_blk, n_blk;
    logic [STAT_W-1:0]  r_status, n_status;

    logic [POS_W-1:0]   dblk;
    logic               out_range;
    logic [LVL_W-1:0]   blen;
    logic [LVL_W-1:0]   tk;
    logic               tdone;
    logic               bt_fail;
    logic [LVL_W-1:0]   node_sh;
    logic [POS_W-1:0]   node_start;
    logic [POS_W-1:0]   child_pos;
    logic [BYTE_W-1:0]  byte_ofs;
    logic [DATA_W-1:0]  lo_mask;

    assign dblk       = r_d[POS_W-1:0];
    assign out_range  = r_d[DATA_W-1:POS_W] != '0;
    assign node_sh    = LVL_W'(POS_W) - r_lvl;
    assign node_start = r_pos << node_sh;
    assign child_pos  = {r_pos[POS_W-2:0], dblk[LVL_W'(POS_W - 1) - r_lvl]};
    assign lo_mask    = ~({DATA_W{1'b1}} << i_shift);

    // Bit length of the block count minus one picks the level.
    always_comb begin
        blen = '0;
        for (int i = 0; i < POS_W; i++) begin
            if (dblk[i]) begin
                blen = LVL_W'(i + 1);
            end
        end
    end

    // Backtrack: climb past right children, then step to the right sibling.
    always_comb begin
        tk    = '0;
        tdone = 1'b0;
        for (int i = 0; i < POS_W; i++) begin
            if (!tdone && LVL_W'(i) < r_lvl) begin
                if (r_pos[i]) begin
                    tk = tk + LVL_W'(1);
                end else begin
                    tdone = 1'b1;
                end
            end
        end
        bt_fail = (tk == r_lvl);
    end

    always_comb begin
        n_state  = r_state;
        n_goal   = r_goal;
        n_lvl    = r_lvl;
        n_pos    = r_pos;
        n_blk    = r_blk;
        n_status = r_status;
        o_ram    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_lvl = '0;
                n_pos = '0;
                n_blk = '0;
                if (r_act == ACT_ALLOC) begin
                    n_goal = r_zero ? LVL_W'(POS_W) : LVL_W'(POS_W) - blen;
                    if (!r_zero && out_range) begin
                        n_status = ST_TOOBIG;
                        n_state  = S_DONE;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = '0;
                        n_state     = S_SRCH;
                    end
                end else begin
                    if (out_range) begin
                        n_status = ST_UNKNOWN;
                        n_state  = S_DONE;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = '0;
                        n_state     = S_FWALK;
                    end
                end
            end
            S_SRCH: begin
                if (i_rdata == N_FREE && r_lvl <= r_goal) begin
                    n_lvl   = r_goal;
                    n_pos   = r_pos << (r_goal - r_lvl);
                    n_state = S_MARK;
                end else if (i_rdata == N_SPLIT && r_lvl != r_goal) begin
                    n_lvl       = r_lvl + LVL_W'(1);
                    n_pos       = r_pos << 1;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = node_idx(n_lvl, n_pos);
                end else if (bt_fail) begin
                    n_status = ST_NOSPACE;
                    n_state  = S_DONE;
                end else begin
                    n_lvl       = r_lvl - tk;
                    n_pos       = (r_pos >> tk) + POS_W'(1);
                    o_ram.re    = 1'b1;
                    o_ram.raddr = node_idx(n_lvl, n_pos);
                end
            end
            S_MARK, S_UP: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = node_idx(r_lvl, r_pos);
                o_ram.wdata = (r_state == S_MARK) ? N_USED : N_SPLIT;
                if (r_state == S_MARK) begin
                    n_blk    = node_start;
                    n_status = ST_ALLOC;
                end
                if (r_lvl == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_pos   = r_pos >> 1;
                    n_state = S_UP;
                end
            end
            S_FWALK: begin
                if (i_rdata == N_USED) begin
                    if (r_aligned && node_start == dblk) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = node_idx(r_lvl, r_pos);
                        o_ram.wdata = N_FREE;
                        n_status    = ST_FREED;
                        if (r_lvl == '0) begin
                            n_state = S_DONE;
                        end else begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = node_idx(r_lvl, r_pos ^ POS_W'(1));
                            n_state     = S_FSIB;
                        end
                    end else begin
                        n_status = ST_UNKNOWN;
                        n_state  = S_DONE;
                    end
                end else if (i_rdata == N_SPLIT && r_lvl != LVL_W'(POS_W)) begin
                    n_lvl       = r_lvl + LVL_W'(1);
                    n_pos       = child_pos;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = node_idx(n_lvl, n_pos);
                end else begin
                    n_status = ST_UNKNOWN;
                    n_state  = S_DONE;
                end
            end
            S_FSIB: begin
                if (i_rdata != N_FREE) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl       = r_lvl - LVL_W'(1);
                    n_pos       = r_pos >> 1;
                    o_ram.we    = 1'b1;
                    o_ram.waddr = node_idx(n_lvl, n_pos);
                    o_ram.wdata = N_FREE;
                    if (n_lvl == '0) begin
                        n_state = S_DONE;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = node_idx(n_lvl, n_pos ^ POS_W'(1));
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_goal   <= n_goal;
        r_lvl    <= n_lvl;
        r_pos    <= n_pos;
        r_blk    <= n_blk;
        r_status <= n_status;
        if (r_state == S_IDLE && i_req_valid) begin
            r_act     <= i_action;
            r_shift   <= i_shift;
            r_zero    <= (i_size == '0);
            r_aligned <= (i_offset & lo_mask) == '0;
            r_d       <= (i_action == ACT_ALLOC) ? ((i_size - DATA_W'(1)) >> i_shift)
                                                 : (i_offset >> i_shift);
        end
    end

    assign byte_ofs    = BYTE_W'(r_blk) << r_shift;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.offset = (r_status == ST_ALLOC) ? DATA_W'(byte_ofs) : '0;

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we && o_ram.re |-> o_ram.waddr != o_ram.raddr)
        else $error("node ram read and write hit the same entry");

    a_search_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> r_lvl <= r_goal)
        else $error("search went below the goal level");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> r_state == S_PREP)
        else $error("accepted request did not start decode");

    a_mark_ends_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MARK |=> r_status == ST_ALLOC)
        else $error("marking a node did not yield an allocated status");

endmodule

### rtl/core/buddy_allocator_tree.sv
// Top level of the buddy allocator: stream ports, block-size register, result register.
// Depends on bat_pkg, bat_engine and bat_node_ram.
//
// Usage: s_axis carries one request per transfer. tuser is the action (0 allocate,
//   1 free); tdata holds request_size in [23:0] and free_offset in [47:24].
//   m_axis returns one result per request: tuser is the status (0 allocated,
//   1 freed, 2 no space, 3 too large, 4 unknown offset), tdata the block offset.
//   i_cfg_we/i_cfg_wdata write block_shift (log2 of the minimum block size;
//   values above 16 act as 16). Write it only while no request is in flight.
// Sequencing: one request at a time; each step does at most one node read and one write.
//   Allocate goes through accept and decode, then the left-first search node by node,
//   then goal level + 1 marking writes, then the result; free goes through accept and
//   decode, a walk down the split nodes, a check of each buddy on the way up, then the
//   result. Too large and beyond-region requests go from decode straight to the result.
//   The worst case is a search of most of the tree. The result reaches m_axis through
//   the result register once the engine hands it over.
// Reset: synchronous, active low. All nodes read as free, block_shift returns to 0.
// Stalls: the result register holds a finished result while m_axis_tready is low;
//   the engine still takes the next request and holds its own result until the
//   register frees up, keeping s_axis_tready low meanwhile.
module buddy_allocator_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_size[23:0], free_offset[47:24]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // block_offset[23:0]
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata     // block_shift
);
    import bat_pkg::*;

    logic [SHIFT_W-1:0] r_cfg_shift;
    logic [SHIFT_W-1:0] eff_shift;
    logic               r_out_valid;
    t_result            r_out;
    logic               res_valid;
    logic               res_ready;
    t_result            res;
    t_ram_req           ram_req;
    t_node              ram_rdata;

    // Hold the block-size register; clamp to the largest supported shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_shift <= '0;
        end else if (i_cfg_we) begin
            r_cfg_shift <= i_cfg_wdata;
        end
    end

    assign eff_shift = (r_cfg_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : r_cfg_shift;

    bat_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_size      (s_axis_tdata[23:0]),
        .i_offset    (s_axis_tdata[47:24]),
        .i_shift     (eff_shift),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    bat_node_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Advance the result register whenever it is empty or being drained.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.offset;
    assign m_axis_tuser  = r_out.status;

endmodule

### tb/tb.sv
// Self-checking testbench for buddy_allocator_tree: allocate and free requests
// against a tree predictor. Depends on bat_pkg and the buddy_allocator_tree RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bat_pkg::*;

    // One allocate or free request as it travels on s_axis.
    typedef struct packed {
        logic              act;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] addr;
    } t_alloc_req;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata  = '0;   // request_size[23:0], free_offset[47:24]
    logic              s_axis_tuser  = 1'b0; // action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;         // block_offset[23:0]
    logic [2:0]        m_axis_tuser;         // status
    logic              i_cfg_we      = 1'b0;
    logic [4:0]        i_cfg_wdata   = '0;   // block_shift

    // Requests waiting for the driver, results still owed by the block.
    t_alloc_req        pending_reqs[$];
    t_result           expected_results[$];

    // Predictor state: node tree, block size register, blocks currently held
    // (kept in minimum-block units so they follow a block_shift change).
    t_node             tree_nodes[NODE_CNT];
    logic [4:0]        shift_cfg = '0;
    int unsigned       held_units[$];

    int                send_idle_pct  = 0;
    int                recv_idle_pct  = 0;
    int                holds_asked    = 0;
    int                holds_done     = 0;
    int                hold_left      = 0;
    int                mismatch_count = 0;
    bit                req_taken      = 1'b0;

    buddy_allocator_tree dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Work out the result of one request and update the tree as the block should.
    function automatic t_result buddy_predict(input logic act,
                                              input logic [DATA_W-1:0] size,
                                              input logic [DATA_W-1:0] addr);
        t_result     r;
        int          found;
        int unsigned eff, top, total, lvl, idx, start, half, sib;
        r.status = ST_UNKNOWN;
        r.offset = '0;
        // Clamp the block size: shifts above the top act as the top.
        eff   = (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : shift_cfg;
        top   = eff + LEVELS - 1;
        total = 1 << top;
        if (act == ACT_ALLOC) begin
            if (size > total) begin
                r.status = ST_TOOBIG;
            end else begin
                // Pick the smallest block that still holds the request.
                lvl = 0;
                while (lvl + 1 < LEVELS && (total >> (lvl + 1)) >= size)
                    lvl++;
                // Left-first search: the lowest position whose path ends in a free
                // node, either at the goal level or at a free ancestor above it.
                found = -1;
                for (int p = 0; p < (1 << lvl); p++) begin
                    idx = 0;
                    for (int l = 0; l <= lvl; l++) begin
                        if (tree_nodes[idx] == N_USED)
                            break;
                        if (tree_nodes[idx] == N_FREE) begin
                            found = p;
                            break;
                        end
                        if (l == lvl)
                            break;
                        idx = 2 * idx + 1 + ((p >> (lvl - l - 1)) & 1);
                    end
                    if (found >= 0)
                        break;
                end
                if (found < 0) begin
                    r.status = ST_NOSPACE;
                end else begin
                    idx = (1 << lvl) - 1 + found;
                    tree_nodes[idx] = N_USED;
                    while (idx != 0) begin
                        idx = (idx - 1) / 2;
                        tree_nodes[idx] = N_SPLIT;
                    end
                    r.status = ST_ALLOC;
                    r.offset = DATA_W'(found << (top - lvl));
                    held_units.push_back(found << (LEVELS - 1 - lvl));
                end
            end
        end else if (addr < total) begin
            // Walk down split nodes toward the offset; stop at the first used one.
            idx   = 0;
            start = 0;
            for (lvl = 0; lvl < LEVELS; lvl++) begin
                if (tree_nodes[idx] == N_USED) begin
                    if (start == addr) begin
                        tree_nodes[idx] = N_FREE;
                        while (idx != 0) begin
                            sib = (idx & 1) ? idx + 1 : idx - 1;
                            if (tree_nodes[sib] != N_FREE)
                                break;
                            idx = (idx - 1) / 2;
                            tree_nodes[idx] = N_FREE;
                        end
                        r.status = ST_FREED;
                        for (int k = 0; k < held_units.size(); k++) begin
                            if (held_units[k] == (start >> eff)) begin
                                held_units.delete(k);
                                break;
                            end
                        end
                    end
                    break;
                end
                if (tree_nodes[idx] != N_SPLIT || lvl + 1 >= LEVELS)
                    break;
                half = 1 << (top - lvl - 1);
                if (addr >= start + half) begin
                    start += half;
                    idx = 2 * idx + 2;
                end else begin
                    idx = 2 * idx + 1;
                end
            end
        end
        return r;
    endfunction

    // Driver: offer the next request at the falling edge once the last one is taken.
    always @(negedge i_clk) begin : req_driver
        t_alloc_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.addr, nxt.size};
                s_axis_tuser  <= nxt.act;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus long hold-offs when asked for.
    always @(negedge i_clk) begin : result_ready
        if (holds_done != holds_asked) begin
            holds_done    <= holds_asked;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict each accepted request, check each accepted result in order.
    always @(posedge i_clk) begin : bus_monitor
        t_result want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                want = buddy_predict(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[47:24]);
                expected_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d, offset 0x%0h",
                           m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata !== want.offset) begin
                        $error("block_offset: expected 0x%0h, actual 0x%0h",
                               want.offset, m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic push_req(input logic act, input logic [DATA_W-1:0] size,
                            input logic [DATA_W-1:0] addr);
        t_alloc_req req;
        req.act  = act;
        req.size = size;
        req.addr = addr;
        pending_reqs.push_back(req);
    endtask

    // Hold until every request has gone in and every result has come back.
    task automatic settle();
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
    endtask

    // Write block_shift while the block is idle; the tree is kept as it is.
    task automatic write_shift(input logic [4:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        shift_cfg   = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Mostly well-formed traffic: sized allocations and frees of held blocks,
    // with some noise (bad offsets, oversize requests, fully random fields).
    task automatic run_phase(input int count, input bit with_hold);
        t_alloc_req  req;
        int unsigned eff, total, lv;
        int          roll;
        for (int n = 0; n < count; n++) begin
            wait (pending_reqs.size() < 4);
            if (with_hold && n == count / 3)
                holds_asked++;
            eff      = (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : shift_cfg;
            total    = 1 << (eff + LEVELS - 1);
            req.size = DATA_W'($urandom());
            req.addr = DATA_W'($urandom());
            roll     = $urandom_range(99);
            if (roll < (held_units.size() > 24 ? 35 : 55)) begin
                req.act = ACT_ALLOC;
                case ($urandom_range(15))
                    0: req.size = '0;
                    1: ; // keep the fully random size
                    2: req.size = DATA_W'(total + $urandom_range(1, 300));
                    default: begin
                        lv = ($urandom_range(3) == 0) ? $urandom_range(LEVELS - 1)
                                                      : $urandom_range(3, LEVELS - 1);
                        req.size = DATA_W'($urandom_range(total >> lv,
                                                          (total >> (lv + 1)) + 1));
                    end
                endcase
            end else if (roll < 88 && held_units.size() != 0) begin
                req.act  = ACT_FREE;
                req.addr = DATA_W'(held_units[$urandom_range(held_units.size() - 1)] << eff);
            end else begin
                req.act = ACT_FREE;
                case ($urandom_range(3))
                    0: ; // keep the fully random offset
                    1: req.addr = DATA_W'(total + $urandom_range(0, 1000));
                    2: if (held_units.size() != 0)
                           req.addr = DATA_W'((held_units[$urandom_range(held_units.size() - 1)]
                                               << eff) + 1);
                    default: req.addr = DATA_W'($urandom_range(total - 1));
                endcase
            end
            pending_reqs.push_back(req);
        end
    endtask

    initial begin : stimulus
        foreach (tree_nodes[i])
            tree_nodes[i] = N_FREE;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at 8-byte blocks (1 KiB region).
        send_idle_pct = 26;
        recv_idle_pct = 73;
        write_shift(5'd3);
        push_req(ACT_ALLOC, 24'd0, 24'd0);           // zero size takes one minimum block
        push_req(ACT_ALLOC, 24'd1024, 24'd0);        // whole region, but the root is split
        push_req(ACT_ALLOC, 24'd1025, 24'd0);        // just over the region
        push_req(ACT_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
        push_req(ACT_FREE, 24'd0, 24'd8);            // not the start of a used block
        push_req(ACT_FREE, 24'hFFFFFF, 24'hFFFFFF);  // beyond the region
        push_req(ACT_ALLOC, 24'd9, 24'd0);
        push_req(ACT_ALLOC, 24'd512, 24'd0);
        push_req(ACT_FREE, 24'd0, 24'd0);
        push_req(ACT_FREE, 24'd0, 24'd0);            // double free
        push_req(ACT_FREE, 24'd0, 24'd16);
        push_req(ACT_FREE, 24'd0, 24'd512);          // merges back to the root
        push_req(ACT_ALLOC, 24'd1024, 24'd0);
        push_req(ACT_FREE, 24'd0, 24'd0);
        push_req(ACT_ALLOC, 24'd8, 24'd0);
        push_req(ACT_ALLOC, 24'd8, 24'd0);
        // Change the block size with blocks held: offsets scale with it.
        write_shift(5'd31);
        push_req(ACT_FREE, 24'd0, 24'd65536);
        push_req(ACT_FREE, 24'd0, 24'd8);
        push_req(ACT_ALLOC, 24'hFFFFFF, 24'd0);
        push_req(ACT_ALLOC, 24'h800000, 24'd0);      // fits the region, no room left
        push_req(ACT_ALLOC, 24'h800001, 24'd0);
        push_req(ACT_FREE, 24'd0, 24'd0);
        write_shift(5'd0);
        push_req(ACT_ALLOC, 24'd128, 24'd0);
        push_req(ACT_FREE, 24'd0, 24'd0);

        // Random phases; the tree carries over each block size change.
        run_phase(345, 1'b0);
        write_shift(5'd9);
        send_idle_pct = 73;
        recv_idle_pct = 26;
        run_phase(345, 1'b0);
        write_shift(5'd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(345, 1'b1);
        write_shift(5'd2);
        run_phase(345, 1'b0);

        settle();
        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Drop the run if it hangs.
    initial begin : watchdog
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### buddy_allocator_tree.f
rtl/core/bat_pkg.sv
rtl/core/bat_node_ram.sv
rtl/core/bat_engine.sv
rtl/core/buddy_allocator_tree.sv
tb/tb.sv
